[hw/rtl/toom_pkg.sv]
// Shared types and constants for the TCP option order matcher.
// No dependencies; used by every toom_* module and the top level.
`timescale 1ns / 1ps

package toom_pkg;

  localparam int SLOT_WIDTH = 3;
  localparam int NUM_CODES  = 4;

  localparam logic [SLOT_WIDTH-1:0] TCPO_MSS    = 3'd1;
  localparam logic [SLOT_WIDTH-1:0] TCPO_WSCALE = 3'd2;
  localparam logic [SLOT_WIDTH-1:0] TCPO_TSTAMP = 3'd3;
  localparam logic [SLOT_WIDTH-1:0] TCPO_SACK   = 3'd4;

  localparam logic [NUM_CODES-1:0][SLOT_WIDTH-1:0] OPT_CODES =
    {TCPO_SACK, TCPO_TSTAMP, TCPO_WSCALE, TCPO_MSS};

  typedef enum logic [1:0] {
    RES_CONFLICT = 2'd0,
    RES_ORDER    = 2'd1,
    RES_SAME     = 2'd2
  } match_t;

endpackage

[hw/rtl/toom_decode.sv]
// Stage 1: word compare and per-slot one-hot decode of the option codes.
// Depends on toom_pkg.
`timescale 1ns / 1ps

module toom_decode #(
  parameter int WORD_WIDTH = 64,
  parameter int NUM_SLOTS  = 22
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [63:0]                                  tar_i,
  input  logic [63:0]                                  sig_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output logic                                         same_o,
  output logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] tar_hot_o,
  output logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] sig_hot_o
);

  localparam int PADW = NUM_SLOTS * toom_pkg::SLOT_WIDTH;

  logic                                          v_r;
  logic                                          same_r;
  logic                                          same_nxt;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] tar_hot_r;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] tar_hot_nxt;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] sig_hot_r;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] sig_hot_nxt;
  logic [PADW-1:0]                               tar_pad;
  logic [PADW-1:0]                               sig_pad;

  assign ready_o = !v_r || ready_i;

  always_comb begin
    tar_pad  = PADW'(tar_i[WORD_WIDTH-1:0]);
    sig_pad  = PADW'(sig_i[WORD_WIDTH-1:0]);
    same_nxt = (tar_i[WORD_WIDTH-1:0] == sig_i[WORD_WIDTH-1:0]);
    for (int c = 0; c < toom_pkg::NUM_CODES; c++) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        tar_hot_nxt[c][s] = (tar_pad[s*toom_pkg::SLOT_WIDTH +: toom_pkg::SLOT_WIDTH]
                             == toom_pkg::OPT_CODES[c]);
        sig_hot_nxt[c][s] = (sig_pad[s*toom_pkg::SLOT_WIDTH +: toom_pkg::SLOT_WIDTH]
                             == toom_pkg::OPT_CODES[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      same_r    <= same_nxt;
      tar_hot_r <= tar_hot_nxt;
      sig_hot_r <= sig_hot_nxt;
    end
  end

  assign valid_o   = v_r;
  assign same_o    = same_r;
  assign tar_hot_o = tar_hot_r;
  assign sig_hot_o = sig_hot_r;

endmodule

[hw/rtl/toom_locate.sv]
// Stage 2: per code, first signature position and first/last target position.
// Depends on toom_pkg.
`timescale 1ns / 1ps

module toom_locate #(
  parameter int NUM_SLOTS = 22,
  parameter int PW        = 5
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic                                         same_i,
  input  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] tar_hot_i,
  input  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] sig_hot_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output logic                                         same_o,
  output logic [toom_pkg::NUM_CODES-1:0]               both_o,
  output logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        tar_first_o,
  output logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        tar_last_o,
  output logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        sig_pos_o
);

  logic                                   v_r;
  logic                                   same_r;
  logic [toom_pkg::NUM_CODES-1:0]         both_r;
  logic [toom_pkg::NUM_CODES-1:0]         both_nxt;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_first_r;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_first_nxt;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_last_r;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_last_nxt;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] sig_pos_r;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] sig_pos_nxt;

  assign ready_o = !v_r || ready_i;

  always_comb begin
    for (int c = 0; c < toom_pkg::NUM_CODES; c++) begin
      both_nxt[c]      = (|tar_hot_i[c]) && (|sig_hot_i[c]);
      tar_first_nxt[c] = '0;
      tar_last_nxt[c]  = '0;
      sig_pos_nxt[c]   = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
        if (tar_hot_i[c][s]) begin
          tar_first_nxt[c] = PW'(s);
        end
        if (sig_hot_i[c][s]) begin
          sig_pos_nxt[c] = PW'(s);
        end
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (tar_hot_i[c][s]) begin
          tar_last_nxt[c] = PW'(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      same_r      <= same_i;
      both_r      <= both_nxt;
      tar_first_r <= tar_first_nxt;
      tar_last_r  <= tar_last_nxt;
      sig_pos_r   <= sig_pos_nxt;
    end
  end

  assign valid_o     = v_r;
  assign same_o      = same_r;
  assign both_o      = both_r;
  assign tar_first_o = tar_first_r;
  assign tar_last_o  = tar_last_r;
  assign sig_pos_o   = sig_pos_r;

endmodule

[hw/rtl/toom_order.sv]
// Stage 3: pairwise order check of shared codes and the registered result word.
// Depends on toom_pkg.
`timescale 1ns / 1ps

module toom_order #(
  parameter int PW = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic                                  same_i,
  input  logic [toom_pkg::NUM_CODES-1:0]        both_i,
  input  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_first_i,
  input  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] tar_last_i,
  input  logic [toom_pkg::NUM_CODES-1:0][PW-1:0] sig_pos_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output toom_pkg::match_t                      result_o
);

  logic             v_r;
  logic             conflict;
  toom_pkg::match_t result_r;
  toom_pkg::match_t result_nxt;

  assign ready_o = !v_r || ready_i;

  // conflict: code a seen before code b in the target, but after it in the signature
  always_comb begin
    conflict = 1'b0;
    for (int a = 0; a < toom_pkg::NUM_CODES; a++) begin
      for (int b = 0; b < toom_pkg::NUM_CODES; b++) begin
        if (a != b && both_i[a] && both_i[b] && (tar_first_i[a] < tar_last_i[b])
            && (sig_pos_i[a] > sig_pos_i[b])) begin
          conflict = 1'b1;
        end
      end
    end
    if (same_i) begin
      result_nxt = toom_pkg::RES_SAME;
    end else if (conflict) begin
      result_nxt = toom_pkg::RES_CONFLICT;
    end else begin
      result_nxt = toom_pkg::RES_ORDER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = v_r;
  assign result_o = result_r;

endmodule

[hw/rtl/tcp_option_order_match.sv]
// Top level of the TCP option order matcher: three-stage pipeline.
// Depends on toom_pkg, toom_decode, toom_locate and toom_order.
//
// Usage:
//   in_*  : one word holds a target and a signature option list (3-bit slots
//           packed from bit 0); only the low WORD_WIDTH bits of each are used.
//   out_* : one word per input word, match_result in out_tdata[1:0]:
//           0 ordering conflict, 1 compatible order, 2 identical lists.
// Pipeline: each word passes the decode, locate and compare registers in that
//   order; out_tvalid rises once the compare register holds its result.
// Throughput: one word per cycle while out_tready is high; each stage register
//   holds one word and the stage ready chain lets every stage advance while the next one frees.
// Stall: with out_tready low the words fill the three stages; in_tready drops
//   only when all three hold a word. Nothing is dropped or repeated.
// Reset: rst_n low clears all stage valid bits; in_tready is high after it.
`timescale 1ns / 1ps

module tcp_option_order_match #(
  parameter int WORD_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] target_options, [127:64] signature_options
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata   // [1:0] match_result, [7:2] zero
);

  localparam int NUM_SLOTS = (WORD_WIDTH + toom_pkg::SLOT_WIDTH - 1) / toom_pkg::SLOT_WIDTH;
  localparam int PW        = $clog2(NUM_SLOTS);

  logic                                          v1;
  logic                                          r2;
  logic                                          same1;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] tar_hot1;
  logic [toom_pkg::NUM_CODES-1:0][NUM_SLOTS-1:0] sig_hot1;
  logic                                          v2;
  logic                                          r3;
  logic                                          same2;
  logic [toom_pkg::NUM_CODES-1:0]                both2;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        tar_first2;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        tar_last2;
  logic [toom_pkg::NUM_CODES-1:0][PW-1:0]        sig_pos2;
  toom_pkg::match_t                              result3;

  toom_decode #(
    .WORD_WIDTH (WORD_WIDTH),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (in_tvalid),
    .ready_o   (in_tready),
    .tar_i     (in_tdata[63:0]),
    .sig_i     (in_tdata[127:64]),
    .valid_o   (v1),
    .ready_i   (r2),
    .same_o    (same1),
    .tar_hot_o (tar_hot1),
    .sig_hot_o (sig_hot1)
  );

  toom_locate #(
    .NUM_SLOTS (NUM_SLOTS),
    .PW        (PW)
  ) u_locate (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (v1),
    .ready_o     (r2),
    .same_i      (same1),
    .tar_hot_i   (tar_hot1),
    .sig_hot_i   (sig_hot1),
    .valid_o     (v2),
    .ready_i     (r3),
    .same_o      (same2),
    .both_o      (both2),
    .tar_first_o (tar_first2),
    .tar_last_o  (tar_last2),
    .sig_pos_o   (sig_pos2)
  );

  toom_order #(
    .PW (PW)
  ) u_order (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (v2),
    .ready_o     (r3),
    .same_i      (same2),
    .both_i      (both2),
    .tar_first_i (tar_first2),
    .tar_last_i  (tar_last2),
    .sig_pos_i   (sig_pos2),
    .valid_o     (out_tvalid),
    .ready_i     (out_tready),
    .result_o    (result3)
  );

  assign out_tdata = {6'd0, result3};

`ifndef SYNTH
  // backpressure at the input only when the output is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && v1 && v2))
    else $error("input stalled without a full pipeline");

  a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("invalid match result code");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'd0))
    else $error("nonzero padding in result word");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (!out_tvalid && !v1 && !v2))
    else $error("pipeline not empty after reset");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench for tcp_option_order_match: directed and random option lists.
// Depends on toom_pkg and the tcp_option_order_match RTL; compares every result word in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOT_WIDTH  = toom_pkg::SLOT_WIDTH;
  localparam int NUM_SLOTS   = (64 + SLOT_WIDTH - 1) / SLOT_WIDTH;
  localparam int RAND_WORDS  = 1150;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // [63:0] target_options, [127:64] signature_options
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;       // [1:0] match_result, [7:2] zero

  bit idle_on = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  tcp_option_order_match uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic bit is_key(logic [SLOT_WIDTH-1:0] code);
    return code == toom_pkg::TCPO_MSS || code == toom_pkg::TCPO_WSCALE ||
           code == toom_pkg::TCPO_TSTAMP || code == toom_pkg::TCPO_SACK;
  endfunction

  class match_board;
    toom_pkg::match_t expected_matches[$];
    int               words;
    int               mismatches;
    int               seen[3];

    function int first_slot(logic [63:0] sig, logic [SLOT_WIDTH-1:0] code);
      logic [63:0] s;
      s = sig;
      for (int p = 0; p < NUM_SLOTS; p++) begin
        if (s == 0) return -1;
        if (s[SLOT_WIDTH-1:0] == code) return p;
        s = s >> SLOT_WIDTH;
      end
      return -1;
    endfunction

    function toom_pkg::match_t predict_match(logic [63:0] tar, logic [63:0] sig);
      logic [63:0]           t;
      logic [SLOT_WIDTH-1:0] code;
      int                    last;
      int                    pos;
      if (tar == sig) return toom_pkg::RES_SAME;
      t = tar;
      last = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (t == 0) break;
        code = t[SLOT_WIDTH-1:0];
        t = t >> SLOT_WIDTH;
        if (!is_key(code)) continue;
        pos = first_slot(sig, code);
        if (pos < 0) continue;
        if (pos < last) return toom_pkg::RES_CONFLICT;
        last = pos;
      end
      return toom_pkg::RES_ORDER;
    endfunction

    function void note_word(logic [63:0] tar, logic [63:0] sig);
      expected_matches = {expected_matches, predict_match(tar, sig)};
      words++;
    endfunction

    function void check_word(logic [7:0] data);
      toom_pkg::match_t want;
      if (expected_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result 0x%02h arrived with nothing pending", $time, data);
        return;
      end
      want = expected_matches.pop_front();
      seen[want]++;
      if (data !== {6'b0, want}) begin
        mismatches++;
        $display("%0t: match_result expected %0d, actual %0d (tdata 0x%02h)",
                 $time, want, data[1:0], data);
      end
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  match_board board = new();

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, board.pending());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold off the result side for random stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left <= rand_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_WIDTH-1:0] noise_code();
    int v;
    v = $urandom_range(4, 7);
    return (v == 4) ? 3'd0 : v[SLOT_WIDTH-1:0];
  endfunction

  function automatic logic [63:0] pack_slots(logic [SLOT_WIDTH-1:0] codes[$]);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < codes.size() && i < NUM_SLOTS - 1; i++)
      w[i*SLOT_WIDTH +: SLOT_WIDTH] = codes[i];
    if ($urandom_range(0, 9) == 0) w[63] = 1'b1;
    return w;
  endfunction

  function automatic logic [63:0] perm_list();
    logic [SLOT_WIDTH-1:0] order[4];
    logic [SLOT_WIDTH-1:0] q[$];
    logic [SLOT_WIDTH-1:0] tmp;
    int                    j;
    int                    keep;
    order = '{toom_pkg::TCPO_MSS, toom_pkg::TCPO_WSCALE, toom_pkg::TCPO_TSTAMP,
              toom_pkg::TCPO_SACK};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    keep = $urandom_range(1, 4);
    for (int i = 0; i < keep; i++) begin
      repeat ($urandom_range(0, 2)) q = {q, noise_code()};
      q = {q, order[i]};
      if ($urandom_range(0, 9) == 0) q = {q, order[$urandom_range(0, i)]};
    end
    repeat ($urandom_range(0, 2)) q = {q, noise_code()};
    return pack_slots(q);
  endfunction

  function automatic logic [63:0] same_order(logic [63:0] tar);
    logic [SLOT_WIDTH-1:0] q[$];
    logic [SLOT_WIDTH-1:0] c;
    logic [63:0]           t;
    t = tar;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      c = t[SLOT_WIDTH-1:0];
      t = t >> SLOT_WIDTH;
      if (is_key(c) && $urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(0, 1)) q = {q, noise_code()};
        q = {q, c};
      end
    end
    return pack_slots(q);
  endfunction

  function automatic logic [63:0] code_list();
    logic [SLOT_WIDTH-1:0] q[$];
    logic [SLOT_WIDTH-1:0] c;
    repeat ($urandom_range(0, NUM_SLOTS - 1)) begin
      c = ($urandom_range(0, 2) == 0) ? noise_code() : SLOT_WIDTH'($urandom_range(1, 4));
      q = {q, c};
    end
    return pack_slots(q);
  endfunction

  task automatic send_word(logic [63:0] tar, logic [63:0] sig);
    in_tvalid <= 1'b1;
    in_tdata  <= {sig, tar};
    do @(posedge clk); while (!in_tready);
    board.note_word(tar, sig);
  endtask

  task automatic idle_gap();
    int g;
    g = rand_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {rand64(), rand64()};
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    logic [63:0] tar;
    logic [63:0] sig;
    int          r;
    logic [63:0] dir_tar[$];
    logic [63:0] dir_sig[$];

    dir_tar = '{64'd0, '1, 64'd0, '1, 64'o21, 64'o21, 64'o4321, 64'o4321,
                64'o7650567, 64'o111, 64'o121, 64'o321, 64'o21, 64'o12,
                {1'b1, 63'o2}, {1'b1, 63'o2}, 64'o1000002, {32{2'b10}},
                '1, {32{2'b01}}};
    dir_sig = '{64'd0, '1, '1, 64'd0, 64'o12, 64'o5021, 64'o1234, 64'o7654321,
                64'o1234, 64'o1, 64'o21, 64'o31, 64'o2001, 64'o2001,
                {1'b1, 63'o20}, 64'o12, 64'o12, {32{2'b01}},
                64'o1, {32{2'b10}}};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners back to back, then with gaps
    foreach (dir_tar[i]) send_word(dir_tar[i], dir_sig[i]);
    idle_on = 1'b1;
    foreach (dir_tar[i]) begin
      send_word(dir_tar[i], dir_sig[i]);
      idle_gap();
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 150 == 0) idle_on = (n % 450 != 0);
      if (n == 400) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        tar = code_list();
        sig = tar;
      end else if (r < 22) begin
        tar = rand64();
        sig = rand64();
      end else if (r < 45) begin
        tar = perm_list();
        sig = perm_list();
      end else if (r < 72) begin
        tar = perm_list();
        sig = same_order(tar);
      end else begin
        tar = code_list();
        sig = code_list();
      end
      send_word(tar, sig);
      idle_gap();
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d words: %0d conflicts, %0d compatible, %0d identical; %0d mismatches",
             board.words, board.seen[toom_pkg::RES_CONFLICT], board.seen[toom_pkg::RES_ORDER],
             board.seen[toom_pkg::RES_SAME], board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
